/* hdl/mtseq_pkg.sv */
// Shared types, constants and decode functions for the melody tone sequencer.
`timescale 1ns / 1ps

package mtseq_pkg;

    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int PERIOD_W    = 12;
    localparam int INDEX_W     = 4;
    localparam int LENGTH_W    = 5;
    localparam int TPU_W       = 16;
    localparam int CODE_W      = 4;
    localparam int DIGIT_W     = 3;
    localparam int ENTRY_W     = CODE_W + DIGIT_W;
    localparam int TICKS_W     = TPU_W + DIGIT_W;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CHAR_SHARP = 8'h23;
    localparam logic [CHAR_W-1:0] CHAR_FLAT  = 8'h5E;
    localparam logic [TPU_W-1:0]  TPU_RESET  = 16'd125;

    typedef enum logic [OP_W-1:0] {
        OP_CHAR   = 2'd0,
        OP_COMMIT = 2'd1,
        OP_TICK   = 2'd2,
        OP_IDLE   = 2'd3
    } t_op;

    // Where the period reported with an item comes from.
    typedef enum logic [1:0] {
        PSRC_HOLD,
        PSRC_SILENT,
        PSRC_NOTE
    } t_period_src;

    // Truncated 1e6 / f for codes C..B; rest and unused codes give silence.
    function automatic logic [PERIOD_W-1:0] tone_period(input logic [CODE_W-1:0] code);
        logic [PERIOD_W-1:0] p;
        begin
            case (code)
                4'd1:    p = 12'd3822;
                4'd2:    p = 12'd3607;
                4'd3:    p = 12'd3405;
                4'd4:    p = 12'd3214;
                4'd5:    p = 12'd3033;
                4'd6:    p = 12'd2863;
                4'd7:    p = 12'd2702;
                4'd8:    p = 12'd2551;
                4'd9:    p = 12'd2407;
                4'd10:   p = 12'd2272;
                4'd11:   p = 12'd2145;
                4'd12:   p = 12'd2024;
                default: p = '0;
            endcase
            return p;
        end
    endfunction

    // Tone code 1..12 of a collected name, 0 when the name is not recognized.
    function automatic logic [CODE_W-1:0] name_code(input logic [CHAR_W-1:0] first,
                                                    input logic [CHAR_W-1:0] second,
                                                    input logic [1:0]        count);
        logic [CODE_W-1:0] semi;
        logic              is_letter;
        logic [CODE_W-1:0] code;
        begin
            is_letter = 1'b1;
            case (first)
                "C":     semi = 4'd0;
                "D":     semi = 4'd2;
                "E":     semi = 4'd4;
                "F":     semi = 4'd5;
                "G":     semi = 4'd7;
                "A":     semi = 4'd9;
                "B":     semi = 4'd11;
                default: begin
                    semi      = 4'd0;
                    is_letter = 1'b0;
                end
            endcase
            code = '0;
            if (is_letter && count == 2'd1) begin
                code = semi + 4'd1;
            end else if (is_letter && count == 2'd2) begin
                if (second == CHAR_SHARP) begin
                    code = (semi == 4'd4 || semi == 4'd11) ? 4'd0 : semi + 4'd2;
                end else if (second == CHAR_FLAT) begin
                    code = (semi == 4'd0 || semi == 4'd5) ? 4'd0 : semi;
                end
            end
            return code;
        end
    endfunction

endpackage

/* hdl/mtseq_ifs.sv */
// Valid/ready channel interfaces for items, results and the configuration write.
`timescale 1ns / 1ps

interface mtseq_in_if;
    import mtseq_pkg::*;
    logic                 valid;
    logic                 ready;
    t_op                  op;
    logic [CHAR_W-1:0]    char_byte;
    modport source (output valid, op, char_byte, input ready);
    modport sink   (input valid, op, char_byte, output ready);
endinterface

interface mtseq_out_if;
    import mtseq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [PERIOD_W-1:0]  pwm_period_us;
    logic [INDEX_W-1:0]   note_index;
    logic [LENGTH_W-1:0]  tune_length;
    logic                 note_started;
    logic                 bad_note;
    logic                 dropped_note;
    modport source (output valid, pwm_period_us, note_index, tune_length, note_started,
                    bad_note, dropped_note, input ready);
    modport sink   (input valid, pwm_period_us, note_index, tune_length, note_started,
                    bad_note, dropped_note, output ready);
endinterface

interface mtseq_cfg_if;
    import mtseq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [TPU_W-1:0]     ticks_per_unit;
    modport source (output valid, ticks_per_unit, input ready);
    modport sink   (input valid, ticks_per_unit, output ready);
endinterface

/* hdl/melody_parse_and_tone_sequencer.sv */
// Top level of the melody tone sequencer: parser, two-bank note store and tick playback.
`timescale 1ns / 1ps

// Usage
//   i_item  : one item per handshake; op selects melody character, end-of-melody
//             commit, one time tick, or idle. char_byte matters only for characters.
//   o_result: exactly one result item per accepted item, in order: tone period
//             in microseconds (0 = silence), play position, active tune length,
//             and the note_started / bad_note / dropped_note flags.
//   i_cfg   : writes ticks_per_unit; always ready. Write it only while idle.
// Timing
//   An accepted item passes the middle stage, then the result register. One item
//   per cycle is sustained while o_result is ready: the note store is a single
//   RAM with one write port (parser) and one read port (playback), one access
//   per item, and the read data is used in the stage after acceptance.
// Stalls
//   A result register feeds o_result; a held result still lets the middle stage
//   fill, so one more item is taken before i_item.ready drops.
// Reset
//   Synchronous, active low. Clears the parser, bank select, lengths, position,
//   tick counter and period, sets ticks_per_unit to 125. Store contents are
//   not cleared; only written entries are ever played.
module melody_parse_and_tone_sequencer #(
    parameter int MAX_NOTES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mtseq_cfg_if.sink   i_cfg,
    mtseq_in_if.sink    i_item,
    mtseq_out_if.source o_result
);

    import mtseq_pkg::*;

    localparam int DEPTH = 2 * MAX_NOTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_NOTES + 1);           // counts 0..MAX_NOTES
    localparam int PW    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    // Store address of a position within a bank.
    function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [PW-1:0] pos);
        return bank ? AW'(MAX_NOTES) + AW'(pos) : AW'(pos);
    endfunction

    // Architectural state
    logic                r_bank,   n_bank;
    logic                r_ready,  n_ready;
    logic [CW-1:0]       r_pc,     n_pc;
    logic [CW-1:0]       r_al,     n_al;
    logic [PW-1:0]       r_pos,    n_pos;
    logic [TICKS_W-1:0]  r_tr,     n_tr;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [CHAR_W-1:0]   r_nf,     n_nf;
    logic [CHAR_W-1:0]   r_ns,     n_ns;
    logic [1:0]          r_nc,     n_nc;
    logic [TPU_W-1:0]    r_tpu;

    // Middle stage: item waiting for its store read
    logic                r_s1_valid;
    logic [PW-1:0]       r_s1_pos;
    logic [CW-1:0]       r_s1_al;
    logic                r_s1_bad;
    logic                r_s1_dropped;
    t_period_src         r_s1_src;
    logic                n_bad, n_dropped;
    t_period_src         n_src;

    // Result register
    logic                r_o_valid;
    logic [PERIOD_W-1:0] r_o_period;
    logic [INDEX_W-1:0]  r_o_index;
    logic [LENGTH_W-1:0] r_o_length;
    logic                r_o_started;
    logic                r_o_bad;
    logic                r_o_dropped;

    // Store access
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [ENTRY_W-1:0]  wr_data, rd_data;

    logic                accept, s1_adv;
    logic [CODE_W-1:0]   rd_code;
    logic [DIGIT_W-1:0]  rd_digit;
    logic [TICKS_W-1:0]  note_len, s1_tr_start, tr_eff;
    logic [PERIOD_W-1:0] s1_period;

    // Working values of the parse/playback step
    logic [CW-1:0]       pc_eff;
    logic [CHAR_W-1:0]   nf_eff, ns_eff;
    logic [1:0]          nc_eff;
    logic [CODE_W-1:0]   code;
    logic [CW-1:0]       pos_p1;
    logic                is_digit;

    mtseq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshakes: the middle stage moves on when the result register frees up.
    assign s1_adv        = r_s1_valid && (!r_o_valid || o_result.ready);
    assign i_item.ready  = !r_s1_valid || s1_adv;
    assign accept        = i_item.valid && i_item.ready;
    assign i_cfg.ready   = 1'b1;

    // Note fetched for a starting tick: period and length in ticks.
    assign rd_code     = rd_data[ENTRY_W-1:DIGIT_W];
    assign rd_digit    = rd_data[DIGIT_W-1:0];
    assign note_len    = (TICKS_W'(rd_digit) + TICKS_W'(1)) * TICKS_W'(r_tpu);
    assign s1_tr_start = (note_len == '0) ? '0 : note_len - TICKS_W'(1);

    always_comb begin
        case (r_s1_src)
            PSRC_NOTE:   s1_period = tone_period(rd_code);
            PSRC_SILENT: s1_period = '0;
            default:     s1_period = r_period;
        endcase
    end

    // Forward the tick count of a note that started one item earlier; its
    // store read lands only now.
    assign tr_eff = (r_s1_valid && r_s1_src == PSRC_NOTE) ? s1_tr_start : r_tr;

    always_comb begin
        n_bank    = r_bank;
        n_ready   = r_ready;
        n_pc      = r_pc;
        n_al      = r_al;
        n_pos     = r_pos;
        n_nf      = r_nf;
        n_ns      = r_ns;
        n_nc      = r_nc;
        n_tr      = (s1_adv && r_s1_src == PSRC_NOTE) ? s1_tr_start : r_tr;
        n_period  = s1_adv ? s1_period : r_period;
        n_bad     = 1'b0;
        n_dropped = 1'b0;
        n_src     = PSRC_HOLD;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = '0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        pos_p1    = CW'(r_pos) + CW'(1);
        // A character after an uncommitted-yet-ready tune withdraws the commit.
        pc_eff    = r_ready ? '0 : r_pc;
        nf_eff    = r_ready ? '0 : r_nf;
        ns_eff    = r_ready ? '0 : r_ns;
        nc_eff    = r_ready ? '0 : r_nc;
        code      = name_code(nf_eff, ns_eff, nc_eff);
        is_digit  = (i_item.char_byte > CHAR_ZERO) && (i_item.char_byte < CHAR_NINE);

        if (accept) begin
            unique case (i_item.op)
                OP_CHAR: begin
                    n_ready = 1'b0;
                    n_pc    = pc_eff;
                    n_nf    = nf_eff;
                    n_ns    = ns_eff;
                    n_nc    = nc_eff;
                    if (is_digit) begin
                        n_bad = (code == '0);
                        if (pc_eff >= CW'(MAX_NOTES)) begin
                            n_dropped = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = bank_addr(!r_bank, pc_eff[PW-1:0]);
                            wr_data = {code, DIGIT_W'(i_item.char_byte - CHAR_ZERO - 8'd1)};
                            n_pc    = pc_eff + CW'(1);
                        end
                        n_nf = '0;
                        n_ns = '0;
                        n_nc = '0;
                    end else begin
                        if (nc_eff == 2'd0) begin
                            n_nf = i_item.char_byte;
                        end else if (nc_eff == 2'd1) begin
                            n_ns = i_item.char_byte;
                        end
                        if (nc_eff != 2'd3) begin
                            n_nc = nc_eff + 2'd1;
                        end
                    end
                end
                OP_COMMIT: begin
                    n_ready = 1'b1;
                    n_nf    = '0;
                    n_ns    = '0;
                    n_nc    = '0;
                end
                OP_TICK: begin
                    if (tr_eff == '0) begin
                        n_tr = tr_eff;
                        if (r_al == '0 || pos_p1 >= r_al) begin
                            // Loop wrap: swap in a committed tune here.
                            if (r_ready) begin
                                n_bank  = !r_bank;
                                n_al    = r_pc;
                                n_pc    = '0;
                                n_ready = 1'b0;
                            end
                            n_pos = '0;
                        end else begin
                            n_pos = r_pos + PW'(1);
                        end
                        if (n_al == '0) begin
                            n_src = PSRC_SILENT;
                        end else begin
                            n_src   = PSRC_NOTE;
                            rd_en   = 1'b1;
                            rd_addr = bank_addr(n_bank, n_pos);
                        end
                    end else begin
                        n_tr = tr_eff - TICKS_W'(1);
                    end
                end
                OP_IDLE: begin
                    n_src = PSRC_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank     <= 1'b0;
            r_ready    <= 1'b0;
            r_pc       <= '0;
            r_al       <= '0;
            r_pos      <= '0;
            r_tr       <= '0;
            r_period   <= '0;
            r_nf       <= '0;
            r_ns       <= '0;
            r_nc       <= '0;
            r_tpu      <= TPU_RESET;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_bank   <= n_bank;
            r_ready  <= n_ready;
            r_pc     <= n_pc;
            r_al     <= n_al;
            r_pos    <= n_pos;
            r_tr     <= n_tr;
            r_period <= n_period;
            r_nf     <= n_nf;
            r_ns     <= n_ns;
            r_nc     <= n_nc;
            if (i_cfg.valid) begin
                r_tpu <= i_cfg.ticks_per_unit;
            end
            // Middle stage fills on accept, drains when it moves on.
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            // Result register: load from the middle stage, drop once taken.
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos     <= n_pos;
            r_s1_al      <= n_al;
            r_s1_bad     <= n_bad;
            r_s1_dropped <= n_dropped;
            r_s1_src     <= n_src;
        end
        if (s1_adv) begin
            r_o_period  <= s1_period;
            r_o_index   <= INDEX_W'(r_s1_pos);
            r_o_length  <= LENGTH_W'(r_s1_al);
            r_o_started <= (r_s1_src == PSRC_NOTE);
            r_o_bad     <= r_s1_bad;
            r_o_dropped <= r_s1_dropped;
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.pwm_period_us = r_o_period;
    assign o_result.note_index    = r_o_index;
    assign o_result.tune_length   = r_o_length;
    assign o_result.note_started  = r_o_started;
    assign o_result.bad_note      = r_o_bad;
    assign o_result.dropped_note  = r_o_dropped;

endmodule

/* hdl/mtseq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mtseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
